// ----- design/jpr_pkg.sv -----
// ----------------------------------------------------------------------------
// jpr_pkg
// Shared types and constants for the joypad port register block.
// ----------------------------------------------------------------------------
package jpr_pkg;

    localparam int unsigned NUM_BYTES  = 4;
    localparam int unsigned PAD_BITS   = 21;

    localparam logic [7:0] ID_BASE     = 8'h2F;
    localparam logic [7:0] ID_NTSC     = 8'h10;
    localparam logic [3:0] NIB_MASK    = 4'h0F;
    localparam logic [1:0] OFF_MASK    = 2'h3;

    // Byte offsets with special read behavior
    localparam logic [1:0] OFF_BUTTONS = 2'd0;
    localparam logic [1:0] OFF_ROWSEL  = 2'd1;
    localparam logic [1:0] OFF_ID      = 2'd3;

    typedef enum logic [1:0] {
        MODE_RD_BYTE = 2'd0,
        MODE_RD_WORD = 2'd1,
        MODE_WR_BYTE = 2'd2,
        MODE_WR_WORD = 2'd3
    } mode_t;

    typedef logic [NUM_BYTES-1:0][7:0] port_bytes_t;

    // Write request from the input stage to the byte store
    typedef struct packed {
        logic        en;
        logic        word;
        logic [1:0]  offset;
        logic [15:0] data;
    } wr_req_t;

endpackage

// ----- design/jpr_regfile.sv -----
// ----------------------------------------------------------------------------
// jpr_regfile
// Four stored port bytes; byte and word writes, word writes wrap mod 4.
// ----------------------------------------------------------------------------
module jpr_regfile
    import jpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  wr_req_t     wr,
    output port_bytes_t bytes
);

    port_bytes_t bytes_reg;
    port_bytes_t bytes_next;
    logic [1:0]  off_hi;
    logic [1:0]  off_lo;

    assign off_hi = wr.offset;
    assign off_lo = (wr.offset + 2'd1) & OFF_MASK;

    always_comb begin
        bytes_next = bytes_reg;
        if (wr.en) begin
            if (wr.word) begin
                // high byte first, second byte at the next offset
                bytes_next[off_hi] = wr.data[15:8];
                bytes_next[off_lo] = wr.data[7:0];
            end else begin
                bytes_next[off_hi] = wr.data[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg <= '0;
        end else begin
            bytes_reg <= bytes_next;
        end
    end

    assign bytes = bytes_reg;

endmodule

// ----- design/jpr_read_unit.sv -----
// ----------------------------------------------------------------------------
// jpr_read_unit
// Builds the byte or word read result from stored bytes and pad snapshots.
// ----------------------------------------------------------------------------
module jpr_read_unit
    import jpr_pkg::*;
(
    input  port_bytes_t         bytes,
    input  logic                ntsc,
    input  logic                word,
    input  logic [1:0]          offset,
    input  logic [PAD_BITS-1:0] pad0,
    input  logic [PAD_BITS-1:0] pad1,
    output logic [15:0]         read_data
);

    logic [1:0]           row0;
    logic [1:0]           row1;
    logic [3:0]           col0;
    logic [3:0]           col1;
    logic [7:0]           id_byte;
    logic [NUM_BYTES-1:0][7:0] view;
    logic [1:0]           off_lo;

    function automatic logic [1:0] row_of(input logic [3:0] nib);
        logic [1:0] r;
        if (!nib[0]) begin
            r = 2'd0;
        end else if (!nib[1]) begin
            r = 2'd1;
        end else if (!nib[2]) begin
            r = 2'd2;
        end else begin
            r = 2'd3;
        end
        return r;
    endfunction

    function automatic logic [3:0] cols_of(input logic [PAD_BITS-1:0] pad,
                                           input logic [1:0] row);
        logic [3:0] c;
        case (row)
            2'd0:    c = pad[3:0];
            2'd1:    c = pad[7:4];
            2'd2:    c = pad[11:8];
            default: c = pad[15:12];
        endcase
        return c;
    endfunction

    assign row0 = row_of(bytes[OFF_ROWSEL][3:0] & NIB_MASK);
    assign row1 = row_of(bytes[OFF_ROWSEL][7:4] & NIB_MASK);
    assign col0 = cols_of(pad0, row0);
    assign col1 = cols_of(pad1, row1);

    always_comb begin
        id_byte = ID_BASE | (ntsc ? ID_NTSC : 8'h00);
        // row 0 carries pause and A; rows 1..3 carry B, C, option
        case (row0)
            2'd0: begin
                id_byte[0] = id_byte[0] ^ pad0[20];
                id_byte[1] = id_byte[1] ^ pad0[16];
            end
            2'd1:    id_byte[1] = id_byte[1] ^ pad0[17];
            2'd2:    id_byte[1] = id_byte[1] ^ pad0[18];
            default: id_byte[1] = id_byte[1] ^ pad0[19];
        endcase
    end

    always_comb begin
        view              = bytes;
        view[OFF_BUTTONS] = ~{col1, col0};
        view[OFF_ID]      = id_byte;
    end

    assign off_lo = (offset + 2'd1) & OFF_MASK;

    always_comb begin
        if (word) begin
            read_data = {view[offset], view[off_lo]};
        end else begin
            read_data = {8'h00, view[offset]};
        end
    end

endmodule

// ----- design/joypad_port_registers.sv -----
// ----------------------------------------------------------------------------
// joypad_port_registers
// Four-byte joypad port: bus accesses in, read results out.
// ----------------------------------------------------------------------------
//  channel   dir  ports                         notes
//  s_        in   s_valid/s_ready + fields      one bus access per transaction
//  m_        out  m_valid/m_ready/m_read_data   reads only, writes give none
//  cfg_      in   cfg_valid/cfg_ready/cfg_data  hardware_is_ntsc, always ready
//
//  One transaction per clock sustained unless a read waits on a stalled m_ side.
//  An access waits in the input register; writes there update the byte store and
//  reads are evaluated into the result register, whose load raises m_valid.
//  Reset clears the port bytes and sets hardware_is_ntsc to 1.
//  A stalled m_ side holds the pending read; writes still drain past it.
// ----------------------------------------------------------------------------
module joypad_port_registers
    import jpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [1:0]          s_offset,
    input  logic [15:0]         s_write_data,
    input  logic [PAD_BITS-1:0] s_pad0_buttons,
    input  logic [PAD_BITS-1:0] s_pad1_buttons,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_read_data,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    logic                in_valid_reg;
    logic                in_valid_next;
    mode_t               in_mode_reg;
    logic [1:0]          in_offset_reg;
    logic [15:0]         in_data_reg;
    logic [PAD_BITS-1:0] in_pad0_reg;
    logic [PAD_BITS-1:0] in_pad1_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [15:0]         out_data_reg;

    logic                ntsc_reg;

    logic                in_is_write;
    logic                advance;
    logic                load_out;
    wr_req_t             wr;
    port_bytes_t         bytes;
    logic [15:0]         rd_data;

    assign in_is_write = (in_mode_reg == MODE_WR_BYTE) || (in_mode_reg == MODE_WR_WORD);

    // a write retires in place; a read needs the result register free
    assign advance  = in_valid_reg && (in_is_write || !out_valid_reg || m_ready);
    assign load_out = advance && !in_is_write;
    assign s_ready  = !in_valid_reg || advance;

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = load_out || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ntsc_reg      <= 1'b1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                ntsc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg   <= mode_t'(s_mode);
            in_offset_reg <= s_offset;
            in_data_reg   <= s_write_data;
            in_pad0_reg   <= s_pad0_buttons;
            in_pad1_reg   <= s_pad1_buttons;
        end
        if (load_out) begin
            out_data_reg <= rd_data;
        end
    end

    assign wr.en     = advance && in_is_write;
    assign wr.word   = (in_mode_reg == MODE_WR_WORD);
    assign wr.offset = in_offset_reg;
    assign wr.data   = in_data_reg;

    jpr_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .bytes   (bytes)
    );

    jpr_read_unit u_read_unit (
        .bytes     (bytes),
        .ntsc      (ntsc_reg),
        .word      (in_mode_reg == MODE_RD_WORD),
        .offset    (in_offset_reg),
        .pad0      (in_pad0_reg),
        .pad1      (in_pad1_reg),
        .read_data (rd_data)
    );

    assign cfg_ready   = 1'b1;
    assign m_valid     = out_valid_reg;
    assign m_read_data = out_data_reg;

    // a write transaction never produces a result
    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_is_write && !out_valid_reg) |=> !out_valid_reg)
        else $error("write transaction produced a result");

    // a read that leaves the input stage always shows up as a result
    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_is_write) |=> out_valid_reg)
        else $error("read transaction lost");

    // a read blocked by a stalled result holds its access unchanged
    a_blocked_read_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_is_write && out_valid_reg && !m_ready)
        |=> (in_valid_reg && $stable(in_mode_reg) && $stable(in_offset_reg)
             && $stable(in_pad0_reg) && $stable(in_pad1_reg)))
        else $error("blocked read changed in input stage");

endmodule

// ----- tb/joypad_port_registers_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joypad_port_registers_tb
// Self-checking bench for the joypad port. A directed table covers reset
// values, row selection for both pads, the id byte flips and word wrap. It is
// followed by random accesses under random source gaps and sink stalls, a long
// sink hold-off and NTSC bit changes. Each read result is checked against its
// row's typed-in value if any, else a model of the port bytes and button mux.
// ----------------------------------------------------------------------------
module joypad_port_registers_tb;
    import jpr_pkg::*;

    localparam int unsigned MAX_GAP      = 17;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 150000;

    // Button numbers and id byte bits they flip
    localparam int unsigned BTN_A      = 16;
    localparam int unsigned BTN_B      = 17;
    localparam int unsigned BTN_C      = 18;
    localparam int unsigned BTN_OPTION = 19;
    localparam int unsigned BTN_PAUSE  = 20;
    localparam logic [7:0]  ID_PAUSE_FLIP = 8'h01;
    localparam logic [7:0]  ID_FIRE_FLIP  = 8'h02;

    typedef struct packed {
        mode_t               mode;
        logic [1:0]          offset;
        logic [15:0]         wdata;
        logic [PAD_BITS-1:0] pad0;
        logic [PAD_BITS-1:0] pad1;
        logic                known;   // result typed in below
        logic [15:0]         result;
    } access_t;

    localparam int unsigned NUM_DIRECTED = 23;
    localparam access_t DIRECTED [0:NUM_DIRECTED-1] = '{
        '{MODE_RD_BYTE, 2'd1, 16'h0000, 21'h000000, 21'h000000, 1'b1, 16'h0000},
        '{MODE_RD_BYTE, 2'd0, 16'h0000, 21'h000000, 21'h000000, 1'b1, 16'h00FF},
        '{MODE_RD_BYTE, 2'd0, 16'h0000, 21'h1FFFFF, 21'h1FFFFF, 1'b1, 16'h0000},
        '{MODE_RD_BYTE, 2'd3, 16'h0000, 21'h000000, 21'h000000, 1'b1, 16'h003F},
        '{MODE_RD_BYTE, 2'd3, 16'h0000, 21'h1FFFFF, 21'h000000, 1'b1, 16'h003C},
        '{MODE_RD_WORD, 2'd3, 16'h0000, 21'h000000, 21'h000000, 1'b1, 16'h3FFF},
        '{MODE_WR_BYTE, 2'd2, 16'hFFFF, 21'h000000, 21'h000000, 1'b0, 16'h0000},
        '{MODE_RD_BYTE, 2'd2, 16'h0000, 21'h000000, 21'h000000, 1'b1, 16'h00FF},
        // word write at the top offset wraps its low byte to offset 0
        '{MODE_WR_WORD, 2'd3, 16'hA55A, 21'h000000, 21'h000000, 1'b0, 16'h0000},
        '{MODE_RD_WORD, 2'd1, 16'h0000, 21'h000000, 21'h000000, 1'b1, 16'h00FF},
        '{MODE_WR_BYTE, 2'd1, 16'h0021, 21'h000000, 21'h000000, 1'b0, 16'h0000},
        '{MODE_RD_BYTE, 2'd0, 16'h0000, 21'h155555, 21'h0AAAAA, 1'b0, 16'h0000},
        '{MODE_RD_BYTE, 2'd3, 16'h0000, 21'h020000, 21'h1FFFFF, 1'b0, 16'h0000},
        '{MODE_WR_BYTE, 2'd1, 16'h0073, 21'h000000, 21'h000000, 1'b0, 16'h0000},
        '{MODE_RD_WORD, 2'd0, 16'h0000, 21'h0AAAAA, 21'h155555, 1'b0, 16'h0000},
        '{MODE_RD_BYTE, 2'd3, 16'h0000, 21'h040000, 21'h000000, 1'b0, 16'h0000},
        '{MODE_WR_WORD, 2'd0, 16'hFFF7, 21'h000000, 21'h000000, 1'b0, 16'h0000},
        '{MODE_RD_WORD, 2'd3, 16'h0000, 21'h080000, 21'h1F0000, 1'b0, 16'h0000},
        '{MODE_RD_BYTE, 2'd0, 16'h0000, 21'h0F0000, 21'h1E1234, 1'b0, 16'h0000},
        '{MODE_WR_WORD, 2'd1, 16'h0000, 21'h000000, 21'h000000, 1'b0, 16'h0000},
        '{MODE_RD_BYTE, 2'd3, 16'h0000, 21'h100000, 21'h000000, 1'b1, 16'h003E},
        '{MODE_RD_WORD, 2'd2, 16'h0000, 21'h000000, 21'h000000, 1'b1, 16'h003F},
        '{MODE_RD_BYTE, 2'd0, 16'h0000, 21'h00000F, 21'h0000F0, 1'b1, 16'h00F0}
    };

    logic                aclk;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [1:0]          s_mode         = '0;
    logic [1:0]          s_offset       = '0;
    logic [15:0]         s_write_data   = '0;
    logic [PAD_BITS-1:0] s_pad0_buttons = '0;
    logic [PAD_BITS-1:0] s_pad1_buttons = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [15:0]         m_read_data;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic                cfg_data       = 1'b0;

    // travels with the payload: a typed-in result for directed rows
    logic                row_known      = 1'b0;
    logic [15:0]         row_result     = '0;

    port_bytes_t         port_shadow    = '0;
    logic                ntsc_shadow    = 1'b1;
    logic [15:0]         pending_reads [$];
    int unsigned         error_count    = 0;
    int unsigned         cycle_count    = 0;
    int unsigned         src_max_gap    = MAX_GAP;
    int unsigned         snk_max_gap    = MAX_GAP;
    bit                  hold_request   = 1'b0;

    joypad_port_registers DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_offset       (s_offset),
        .s_write_data   (s_write_data),
        .s_pad0_buttons (s_pad0_buttons),
        .s_pad1_buttons (s_pad1_buttons),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Lowest clear bit among nibble bits 0..2, else row 3
    function automatic logic [1:0] pad_row(input logic [3:0] nib);
        if (!nib[0]) return 2'd0;
        if (!nib[1]) return 2'd1;
        if (!nib[2]) return 2'd2;
        return 2'd3;
    endfunction

    function automatic logic [7:0] port_read(input logic [1:0] off,
                                             input logic [PAD_BITS-1:0] p0,
                                             input logic [PAD_BITS-1:0] p1);
        logic [1:0] r0;
        logic [1:0] r1;
        logic [7:0] v;
        r0 = pad_row(port_shadow[OFF_ROWSEL][3:0]);
        r1 = pad_row(port_shadow[OFF_ROWSEL][7:4]);
        if (off == OFF_BUTTONS) begin
            for (int k = 0; k < 4; k++) begin
                v[k]     = ~p0[r0 * 4 + k];
                v[k + 4] = ~p1[r1 * 4 + k];
            end
        end else if (off == OFF_ID) begin
            v = ID_BASE | (ntsc_shadow ? ID_NTSC : 8'h00);
            case (r0)
                2'd0: begin
                    if (p0[BTN_PAUSE]) v ^= ID_PAUSE_FLIP;
                    if (p0[BTN_A]) v ^= ID_FIRE_FLIP;
                end
                2'd1: if (p0[BTN_B]) v ^= ID_FIRE_FLIP;
                2'd2: if (p0[BTN_C]) v ^= ID_FIRE_FLIP;
                default: if (p0[BTN_OPTION]) v ^= ID_FIRE_FLIP;
            endcase
        end else begin
            v = port_shadow[off];
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Model update and result check, both on accepted transactions
    always @(posedge aclk) begin
        logic [15:0] want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                ntsc_shadow = cfg_data;
            if (s_valid && s_ready) begin
                case (mode_t'(s_mode))
                    MODE_RD_BYTE: begin
                        want = {8'h00, port_read(s_offset, s_pad0_buttons, s_pad1_buttons)};
                        pending_reads.push_back(row_known ? row_result : want);
                    end
                    MODE_RD_WORD: begin
                        want = {port_read(s_offset, s_pad0_buttons, s_pad1_buttons),
                                port_read(s_offset + 2'd1, s_pad0_buttons, s_pad1_buttons)};
                        pending_reads.push_back(row_known ? row_result : want);
                    end
                    MODE_WR_BYTE:
                        port_shadow[s_offset] = s_write_data[7:0];
                    default: begin
                        port_shadow[s_offset]        = s_write_data[15:8];
                        port_shadow[s_offset + 2'd1] = s_write_data[7:0];
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_reads.size() == 0) begin
                    report_mismatch($sformatf("unexpected read_data %h", m_read_data));
                end else begin
                    want = pending_reads.pop_front();
                    if (m_read_data !== want)
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  m_read_data, want));
                end
            end
        end
    end

    // Result side: random stall before each transaction, or a long hold-off
    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                stall = $urandom_range(0, snk_max_gap);
                if (stall != 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offers one access and returns at the accepting edge, valid still high
    task automatic send_access(input access_t acc);
        int unsigned gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= acc.mode;
        s_offset       <= acc.offset;
        s_write_data   <= acc.wdata;
        s_pad0_buttons <= acc.pad0;
        s_pad1_buttons <= acc.pad1;
        row_known      <= acc.known;
        row_result     <= acc.result;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic access_t random_access(input bit reads_only);
        access_t     acc;
        logic [31:0] rnd;
        acc.mode   = reads_only ? mode_t'($urandom_range(0, 1)) : mode_t'($urandom_range(0, 3));
        rnd        = $urandom_range(0, 3);
        acc.offset = rnd[1:0];
        rnd        = $urandom;
        acc.wdata  = rnd[15:0];
        rnd        = $urandom;
        acc.pad0   = rnd[PAD_BITS-1:0];
        rnd        = $urandom;
        acc.pad1   = rnd[PAD_BITS-1:0];
        acc.known  = 1'b0;
        acc.result = '0;
        return acc;
    endfunction

    task automatic drain_reads();
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
    endtask

    // Only while idle; a trailing write may still be in the input register
    task automatic set_ntsc(input logic value);
        drain_reads();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_access(DIRECTED[i]);

        set_ntsc(1'b0);
        for (int i = 0; i < 150; i++)
            send_access(random_access(1'b0));

        // back-to-back transactions on both sides
        set_ntsc(1'b1);
        src_max_gap = 0;
        snk_max_gap = 0;
        for (int i = 0; i < 150; i++)
            send_access(random_access(1'b0));

        // sink holds off while reads keep coming, so the input backs up
        hold_request = 1'b1;
        for (int i = 0; i < 100; i++)
            send_access(random_access(1'b1));

        // set_ntsc waits for every outstanding read first
        set_ntsc(1'b0);
        src_max_gap = MAX_GAP;
        snk_max_gap = MAX_GAP;
        for (int i = 0; i < 100; i++)
            send_access(random_access(1'b0));

        set_ntsc(1'b1);
        for (int i = 0; i < 100; i++)
            send_access(random_access(1'b0));

        drain_reads();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
